>>> sv/rbhd_pkg.sv
// Shared types and constants for the ray/box hit-distance block.
// No dependencies; imported by every other file of the block.
package rbhd_pkg;

   localparam int COORD_W = 32;          // ray coordinate width
   localparam int ENTRY_W = 16;          // one packed matrix entry
   localparam int CSR_W = 48;            // widest configuration register
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W = 48;           // entry * coordinate
   localparam int SUM_W = 50;            // three products plus scaled offset
   localparam int DSQ_W = 64;            // |d|^2
   localparam int ROOT_W = 32;           // floor(sqrt(|d|^2))
   localparam int SMAG_W = 31;           // local direction magnitude after scaling
   localparam int SQ_W = 2 * SMAG_W;
   localparam int TINY_W = 25;           // a square above this can never be nearly parallel
   localparam int INV_W = 40;
   localparam logic [INV_W-1:0] TINY_SQ_INV = 40'd1000000000000;
   localparam int PN_W = TINY_W + INV_W;
   localparam int SLAB_FRAC = 20;
   localparam int DIST_W = 32;
   localparam int FRONT_STAGES = 6;
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH) + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VISIBLE = 3'd0,
      CSR_COL_X   = 3'd1,
      CSR_COL_Y   = 3'd2,
      CSR_COL_Z   = 3'd3,
      CSR_OFFSET  = 3'd4
   } csr_index_type;

   // classification the front hands to the back
   typedef struct packed {
      logic       reject;
      logic [2:0] near;
   } class_type;

   typedef struct packed {
      logic       vld;
      class_type  cls;
      logic [2:0] neg1;
      logic [2:0] neg2;
   } back_tag_type;

endpackage

>>> sv/ray_box_hit_distance.sv
// Ray against unit box hit distance, fully pipelined: one ray per cycle.
// Latency is set by the bit-per-stage slab dividers, whose quotient
// is 71 - MATRIX_FRAC_BITS bits wide.
// Results stream out with rsp_strobe and cannot be stalled; busy stays low in use.
// Synchronous active-high reset zeroes the configuration, queue control and valid flags.
module ray_box_hit_distance import rbhd_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int MATRIX_FRAC_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [COORD_W-1:0]   req_origin_x,
   input  logic [COORD_W-1:0]   req_origin_y,
   input  logic [COORD_W-1:0]   req_origin_z,
   input  logic [COORD_W-1:0]   req_direction_x,
   input  logic [COORD_W-1:0]   req_direction_y,
   input  logic [COORD_W-1:0]   req_direction_z,
   output logic                 rsp_strobe,
   output logic                 rsp_hit,
   output logic [DIST_W-1:0]    rsp_distance,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int LOC_W = SUM_W - MATRIX_FRAC_BITS;
   localparam int QDATA_W = 6 * LOC_W + DSQ_W;

   logic             visible_ff;
   logic [CSR_W-1:0] col_x_ff;
   logic [CSR_W-1:0] col_y_ff;
   logic [CSR_W-1:0] col_z_ff;
   logic [CSR_W-1:0] offset_ff;

   logic                  accept;
   logic                  f_vld;
   class_type             f_class;
   logic [2:0][LOC_W-1:0] f_lo;
   logic [2:0][LOC_W-1:0] f_ld;
   logic [DSQ_W-1:0]      f_dsq;
   logic                  q_vld;
   class_type             q_class;
   logic [QDATA_W-1:0]    q_data;
   logic [QUEUE_LVL_W-1:0] q_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         visible_ff <= 1'b0;
         col_x_ff   <= '0;
         col_y_ff   <= '0;
         col_z_ff   <= '0;
         offset_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_VISIBLE: visible_ff <= csr_wdata[0];
            CSR_COL_X:   col_x_ff   <= csr_wdata;
            CSR_COL_Y:   col_y_ff   <= csr_wdata;
            CSR_COL_Z:   col_z_ff   <= csr_wdata;
            CSR_OFFSET:  offset_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // hold off new rays only if the queue could overflow with the front full
   assign busy   = q_level > QUEUE_LVL_W'(QUEUE_DEPTH - FRONT_STAGES - 1);
   assign accept = start && !busy;

   rbhd_front #(
      .COORD_FRAC_BITS  (COORD_FRAC_BITS),
      .MATRIX_FRAC_BITS (MATRIX_FRAC_BITS),
      .LOC_W            (LOC_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_vld       (accept),
      .in_origin    ({req_origin_z, req_origin_y, req_origin_x}),
      .in_direction ({req_direction_z, req_direction_y, req_direction_x}),
      .cfg_visible  (visible_ff),
      .cfg_col      ({col_z_ff, col_y_ff, col_x_ff}),
      .cfg_offset   (offset_ff),
      .out_vld      (f_vld),
      .out_class    (f_class),
      .out_lo       (f_lo),
      .out_ld       (f_ld),
      .out_dsq      (f_dsq)
   );

   rbhd_queue #(.DATA_W(QDATA_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_vld),
      .push_class (f_class),
      .push_data  ({f_lo, f_ld, f_dsq}),
      .pop_vld    (q_vld),
      .pop_class  (q_class),
      .pop_data   (q_data),
      .level      (q_level)
   );

   rbhd_back #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .LOC_W           (LOC_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_vld       (q_vld),
      .in_class     (q_class),
      .in_lo        (q_data[QDATA_W-1 -: 3*LOC_W]),
      .in_ld        (q_data[DSQ_W + 3*LOC_W - 1 -: 3*LOC_W]),
      .in_dsq       (q_data[DSQ_W-1:0]),
      .out_strobe   (rsp_strobe),
      .out_hit      (rsp_hit),
      .out_distance (rsp_distance)
   );

endmodule

>>> sv/rbhd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Uses rbhd_pkg only for house consistency; no submodules.
module rbhd_div import rbhd_pkg::*; #(
   parameter int NUM_W = 59,
   parameter int DEN_W = 38
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff  [NUM_W];
   logic [NUM_W-1:0] work_ff [NUM_W];
   logic [DEN_W-1:0] den_ff  [NUM_W];
   logic [DEN_W-1:0] rem_in  [NUM_W];
   logic [NUM_W-1:0] work_in [NUM_W];
   logic [DEN_W-1:0] rem_src [NUM_W];
   logic [NUM_W-1:0] work_src[NUM_W];
   logic [DEN_W-1:0] den_src [NUM_W];
   logic [DEN_W:0]   trial   [NUM_W];
   logic [DEN_W:0]   diff    [NUM_W];

   always_comb begin
      for (int i = 0; i < NUM_W; i++) begin
         if (i == 0) begin
            rem_src[i]  = '0;
            work_src[i] = num;
            den_src[i]  = den;
         end else begin
            rem_src[i]  = rem_ff[i-1];
            work_src[i] = work_ff[i-1];
            den_src[i]  = den_ff[i-1];
         end
         // dividend and quotient share one shift register
         trial[i] = {rem_src[i], work_src[i][NUM_W-1]};
         diff[i]  = trial[i] - {1'b0, den_src[i]};
         if (trial[i] >= {1'b0, den_src[i]}) begin
            rem_in[i]  = diff[i][DEN_W-1:0];
            work_in[i] = {work_src[i][NUM_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = trial[i][DEN_W-1:0];
            work_in[i] = {work_src[i][NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_W; i++) begin
         rem_ff[i]  <= rem_in[i];
         work_ff[i] <= work_in[i];
         den_ff[i]  <= den_src[i];
      end
   end

   assign quo = work_ff[NUM_W-1];

endmodule

>>> sv/rbhd_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on rbhd_pkg for the operand widths.
module rbhd_sqrt import rbhd_pkg::*; (
   input  logic              clock,
   input  logic [DSQ_W-1:0]  rad,
   output logic [ROOT_W-1:0] root
);

   localparam int REM_W = ROOT_W + 2;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [DSQ_W-1:0]  rad_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   logic [REM_W-1:0]  rem_src [ROOT_W];
   logic [ROOT_W-1:0] root_src[ROOT_W];
   logic [DSQ_W-1:0]  rad_src [ROOT_W];
   logic [REM_W-1:0]  cur     [ROOT_W];
   logic [REM_W-1:0]  trial   [ROOT_W];

   always_comb begin
      for (int i = 0; i < ROOT_W; i++) begin
         if (i == 0) begin
            rem_src[i]  = '0;
            root_src[i] = '0;
            rad_src[i]  = rad;
         end else begin
            rem_src[i]  = rem_ff[i-1];
            root_src[i] = root_ff[i-1];
            rad_src[i]  = rad_ff[i-1];
         end
         cur[i]   = {rem_src[i][REM_W-3:0], rad_src[i][DSQ_W-1 -: 2]};
         trial[i] = {root_src[i], 2'b01};
         if (cur[i] >= trial[i]) begin
            rem_in[i]  = cur[i] - trial[i];
            root_in[i] = {root_src[i][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = cur[i];
            root_in[i] = {root_src[i][ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ROOT_W; i++) begin
         rem_ff[i]  <= rem_in[i];
         root_ff[i] <= root_in[i];
         rad_ff[i]  <= {rad_src[i][DSQ_W-3:0], 2'b00};
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

>>> sv/rbhd_front.sv
// Front end: world-to-local transform and per-axis classification.
// Depends on rbhd_pkg; feeds rbhd_queue.
module rbhd_front import rbhd_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int MATRIX_FRAC_BITS = 12,
   parameter int LOC_W = 38
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_vld,
   input  logic [2:0][COORD_W-1:0]     in_origin,
   input  logic [2:0][COORD_W-1:0]     in_direction,
   input  logic                        cfg_visible,
   input  logic [2:0][CSR_W-1:0]       cfg_col,
   input  logic [CSR_W-1:0]            cfg_offset,
   output logic                        out_vld,
   output class_type                   out_class,
   output logic [2:0][LOC_W-1:0]       out_lo,
   output logic [2:0][LOC_W-1:0]       out_ld,
   output logic [DSQ_W-1:0]            out_dsq
);

   localparam int KMAX = LOC_W - SMAG_W;
   localparam int KW = $clog2(KMAX + 1);
   localparam logic signed [LOC_W-1:0] HALF =
      {{(LOC_W-1){1'b0}}, 1'b1} << (COORD_FRAC_BITS - 1);

   logic [FRONT_STAGES-1:0] vld_ff;

   logic signed [ENTRY_W-1:0] mat  [3][3];
   logic signed [ENTRY_W-1:0] offe [3];

   // stage 1
   logic signed [PROD_W-1:0] po_in [3][3];
   logic signed [PROD_W-1:0] pd_in [3][3];
   logic signed [PROD_W-1:0] po_ff [3][3];
   logic signed [PROD_W-1:0] pd_ff [3][3];
   logic signed [DSQ_W-1:0]  d2_in [3];
   logic [DSQ_W-1:0]         d2_ff [3];
   // stage 2
   logic signed [SUM_W-1:0]  so [3];
   logic signed [SUM_W-1:0]  sd [3];
   logic signed [LOC_W-1:0]  lo2_in [3];
   logic signed [LOC_W-1:0]  ld2_in [3];
   logic signed [LOC_W-1:0]  lo2_ff [3];
   logic signed [LOC_W-1:0]  ld2_ff [3];
   logic [DSQ_W-1:0]         dsq2_in;
   logic [DSQ_W-1:0]         dsq2_ff;
   // stage 3
   logic [LOC_W-1:0]         dm [3];
   logic [LOC_W-1:0]         maxm;
   logic [KW-1:0]            k;
   logic [SMAG_W-1:0]        sm3_in [3];
   logic [SMAG_W-1:0]        sm3_ff [3];
   logic signed [LOC_W-1:0]  lo3_ff [3];
   logic signed [LOC_W-1:0]  ld3_ff [3];
   logic [DSQ_W-1:0]         dsq3_ff;
   // stage 4
   logic [SQ_W-1:0]          sq4_in [3];
   logic [SQ_W-1:0]          sq4_ff [3];
   logic signed [LOC_W-1:0]  lo4_ff [3];
   logic signed [LOC_W-1:0]  ld4_ff [3];
   logic [DSQ_W-1:0]         dsq4_ff;
   // stage 5
   logic [DSQ_W-1:0]         ssum5_in;
   logic [DSQ_W-1:0]         ssum5_ff;
   logic [2:0]               tiny5_in;
   logic [2:0]               tiny5_ff;
   logic [PN_W-1:0]          pn5_in [3];
   logic [PN_W-1:0]          pn5_ff [3];
   logic signed [LOC_W-1:0]  lo5_ff [3];
   logic signed [LOC_W-1:0]  ld5_ff [3];
   logic [DSQ_W-1:0]         dsq5_ff;
   // stage 6
   logic [2:0]               near;
   logic [2:0]               outside;
   class_type                class6_in;
   class_type                class6_ff;
   logic signed [LOC_W-1:0]  lo6_ff [3];
   logic signed [LOC_W-1:0]  ld6_ff [3];
   logic [DSQ_W-1:0]         dsq6_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         offe[a] = $signed(cfg_offset[ENTRY_W*a +: ENTRY_W]);
         for (int j = 0; j < 3; j++) begin
            mat[a][j] = $signed(cfg_col[j][ENTRY_W*a +: ENTRY_W]);
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int j = 0; j < 3; j++) begin
            po_in[a][j] = mat[a][j] * $signed(in_origin[j]);
            pd_in[a][j] = mat[a][j] * $signed(in_direction[j]);
         end
         d2_in[a] = $signed(in_direction[a]) * $signed(in_direction[a]);
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         so[a] = (SUM_W'(offe[a]) <<< COORD_FRAC_BITS) + SUM_W'(po_ff[a][0])
               + SUM_W'(po_ff[a][1]) + SUM_W'(po_ff[a][2]);
         sd[a] = SUM_W'(pd_ff[a][0]) + SUM_W'(pd_ff[a][1]) + SUM_W'(pd_ff[a][2]);
         // arithmetic shift rounds toward minus infinity
         lo2_in[a] = LOC_W'(so[a] >>> MATRIX_FRAC_BITS);
         ld2_in[a] = LOC_W'(sd[a] >>> MATRIX_FRAC_BITS);
      end
      dsq2_in = d2_ff[0] + d2_ff[1] + d2_ff[2];
   end

   // scale all three magnitudes by the shift that brings the largest below 2^31
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dm[a] = ld2_ff[a][LOC_W-1] ? LOC_W'(-ld2_ff[a]) : LOC_W'(ld2_ff[a]);
      end
      maxm = dm[0];
      if (dm[1] > maxm) begin
         maxm = dm[1];
      end
      if (dm[2] > maxm) begin
         maxm = dm[2];
      end
      k = '0;
      for (int i = SMAG_W; i < LOC_W; i++) begin
         if (maxm[i]) begin
            k = KW'(i - SMAG_W + 1);
         end
      end
      for (int a = 0; a < 3; a++) begin
         sm3_in[a] = SMAG_W'(dm[a] >> k);
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sq4_in[a] = sm3_ff[a] * sm3_ff[a];
      end
   end

   // sq < ceil(S/1e12) is the same as sq*1e12 < S
   always_comb begin
      ssum5_in = DSQ_W'(sq4_ff[0]) + DSQ_W'(sq4_ff[1]) + DSQ_W'(sq4_ff[2]);
      for (int a = 0; a < 3; a++) begin
         tiny5_in[a] = (sq4_ff[a] >> TINY_W) == '0;
         pn5_in[a]   = sq4_ff[a][TINY_W-1:0] * TINY_SQ_INV;
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         near[a] = (ssum5_ff == '0) || (tiny5_ff[a] && (pn5_ff[a] < PN_W'(ssum5_ff)));
         outside[a] = (lo5_ff[a] < -HALF) || (lo5_ff[a] > HALF);
      end
      class6_in.near   = near;
      class6_in.reject = !cfg_visible || ((near & outside) != 3'b000);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[FRONT_STAGES-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      po_ff    <= po_in;
      pd_ff    <= pd_in;
      for (int a = 0; a < 3; a++) begin
         d2_ff[a] <= DSQ_W'(d2_in[a]);
      end
      lo2_ff   <= lo2_in;
      ld2_ff   <= ld2_in;
      dsq2_ff  <= dsq2_in;
      sm3_ff   <= sm3_in;
      lo3_ff   <= lo2_ff;
      ld3_ff   <= ld2_ff;
      dsq3_ff  <= dsq2_ff;
      sq4_ff   <= sq4_in;
      lo4_ff   <= lo3_ff;
      ld4_ff   <= ld3_ff;
      dsq4_ff  <= dsq3_ff;
      ssum5_ff <= ssum5_in;
      tiny5_ff <= tiny5_in;
      pn5_ff   <= pn5_in;
      lo5_ff   <= lo4_ff;
      ld5_ff   <= ld4_ff;
      dsq5_ff  <= dsq4_ff;
      class6_ff <= class6_in;
      lo6_ff   <= lo5_ff;
      ld6_ff   <= ld5_ff;
      dsq6_ff  <= dsq5_ff;
   end

   assign out_vld   = vld_ff[FRONT_STAGES-1];
   assign out_class = class6_ff;
   assign out_dsq   = dsq6_ff;
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         out_lo[a] = lo6_ff[a];
         out_ld[a] = ld6_ff[a];
      end
   end

endmodule

>>> sv/rbhd_queue.sv
// Short queue between the front and back ends, registered read.
// Depends on rbhd_pkg for depth and the classification type.
module rbhd_queue import rbhd_pkg::*; #(
   parameter int DATA_W = 292
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  class_type              push_class,
   input  logic [DATA_W-1:0]      push_data,
   output logic                   pop_vld,
   output class_type              pop_class,
   output logic [DATA_W-1:0]      pop_data,
   output logic [QUEUE_LVL_W-1:0] level
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int ENT_W = DATA_W + $bits(class_type);

   logic [ENT_W-1:0]       mem [QUEUE_DEPTH];
   logic [ENT_W-1:0]       rd_ff;
   logic                   rd_vld_ff;
   logic [AW-1:0]          wr_ptr_ff;
   logic [AW-1:0]          rd_ptr_ff;
   logic [QUEUE_LVL_W-1:0] count_ff;
   logic [QUEUE_LVL_W-1:0] count_in;
   logic                   pop;

   // the back end never stalls: drain whenever something is held
   assign pop = count_ff != '0;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= {push_class, push_data};
      end
      if (pop) begin
         rd_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff  <= count_in;
         rd_vld_ff <= pop;
      end
   end

   assign pop_vld   = rd_vld_ff;
   assign pop_class = rd_ff[ENT_W-1 -: $bits(class_type)];
   assign pop_data  = rd_ff[DATA_W-1:0];
   assign level     = count_ff;

endmodule

>>> sv/rbhd_back.sv
// Back end: slab divides, |d| root, entry/exit merge and distance scaling.
// Depends on rbhd_pkg, rbhd_div and rbhd_sqrt.
module rbhd_back import rbhd_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int LOC_W = 38
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  class_type             in_class,
   input  logic [2:0][LOC_W-1:0] in_lo,
   input  logic [2:0][LOC_W-1:0] in_ld,
   input  logic [DSQ_W-1:0]      in_dsq,
   output logic                  out_strobe,
   output logic                  out_hit,
   output logic [DIST_W-1:0]     out_distance
);

   localparam int NW = LOC_W + 1;
   localparam int NUM_W = NW + SLAB_FRAC;
   localparam int QW = NUM_W;
   localparam int HW = (QW + 1) / 2;
   localparam int UW = QW - HW;
   localparam int PW = QW + ROOT_W;
   localparam int DL = NUM_W + 3 - ROOT_W;
   localparam logic signed [NW-1:0] HALF =
      {{(NW-1){1'b0}}, 1'b1} << (COORD_FRAC_BITS - 1);

   // operand prep
   logic signed [NW-1:0] lo_e [3];
   logic signed [NW-1:0] n1 [3];
   logic signed [NW-1:0] n2 [3];
   logic signed [LOC_W-1:0] ld_s [3];
   logic [NW-1:0]    n1m_ff [3];
   logic [NW-1:0]    n2m_ff [3];
   logic [LOC_W-1:0] den_ff [3];
   back_tag_type     tag0_in;
   back_tag_type     tag0_ff;
   back_tag_type     tag_ff [NUM_W];

   logic [QW-1:0] q1 [3];
   logic [QW-1:0] q2 [3];

   // merge stages
   logic signed [QW:0] s1 [3];
   logic signed [QW:0] s2 [3];
   logic signed [QW:0] c1_lo_ff [3];
   logic signed [QW:0] c1_hi_ff [3];
   back_tag_type       c1_tag_ff;
   logic signed [QW:0] enter_v;
   logic signed [QW:0] leave_v;
   logic               hit_v;
   logic [QW-1:0]      c2_enter_ff;
   logic               c2_hit_ff;
   logic               c2_vld_ff;

   logic [ROOT_W-1:0]  dlen;
   logic [ROOT_W-1:0]  dl_ff [DL];

   logic [HW+ROOT_W-1:0] plo_ff;
   logic [UW+ROOT_W-1:0] phi_ff;
   logic                 c3_hit_ff;
   logic                 c3_vld_ff;

   logic [PW-1:0]     full;
   logic [PW-1:0]     scaled;
   logic [DIST_W-1:0] dist_in;
   logic [DIST_W-1:0] dist_ff;
   logic              hit_ff;
   logic              strobe_ff;

   always_comb begin
      tag0_in.vld = in_vld;
      tag0_in.cls = in_class;
      for (int a = 0; a < 3; a++) begin
         ld_s[a] = $signed(in_ld[a]);
         lo_e[a] = NW'($signed(in_lo[a]));
         n1[a]   = -HALF - lo_e[a];
         n2[a]   = HALF - lo_e[a];
         tag0_in.neg1[a] = n1[a][NW-1] ^ ld_s[a][LOC_W-1];
         tag0_in.neg2[a] = n2[a][NW-1] ^ ld_s[a][LOC_W-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         n1m_ff[a] <= n1[a][NW-1] ? NW'(-n1[a]) : NW'(n1[a]);
         n2m_ff[a] <= n2[a][NW-1] ? NW'(-n2[a]) : NW'(n2[a]);
         den_ff[a] <= ld_s[a][LOC_W-1] ? LOC_W'(-ld_s[a]) : LOC_W'(ld_s[a]);
      end
   end

   genvar ga;
   generate
      for (ga = 0; ga < 3; ga++) begin : g_axis
         rbhd_div #(.NUM_W(NUM_W), .DEN_W(LOC_W)) u_div_near (
            .clock (clock),
            .num   ({n1m_ff[ga], {SLAB_FRAC{1'b0}}}),
            .den   (den_ff[ga]),
            .quo   (q1[ga])
         );
         rbhd_div #(.NUM_W(NUM_W), .DEN_W(LOC_W)) u_div_far (
            .clock (clock),
            .num   ({n2m_ff[ga], {SLAB_FRAC{1'b0}}}),
            .den   (den_ff[ga]),
            .quo   (q2[ga])
         );
      end
   endgenerate

   rbhd_sqrt u_sqrt (
      .clock (clock),
      .rad   (in_dsq),
      .root  (dlen)
   );

   // root finishes early; hold it until the slab merge is done
   always_ff @(posedge clock) begin
      for (int i = 0; i < DL; i++) begin
         if (i == 0) begin
            dl_ff[i] <= dlen;
         end else begin
            dl_ff[i] <= dl_ff[i-1];
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         s1[a] = tag_ff[NUM_W-1].neg1[a] ? -$signed({1'b0, q1[a]}) : $signed({1'b0, q1[a]});
         s2[a] = tag_ff[NUM_W-1].neg2[a] ? -$signed({1'b0, q2[a]}) : $signed({1'b0, q2[a]});
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         c1_lo_ff[a] <= (s1[a] > s2[a]) ? s2[a] : s1[a];
         c1_hi_ff[a] <= (s1[a] > s2[a]) ? s1[a] : s2[a];
      end
   end

   // nearly parallel axes take no part in the entry/exit merge
   always_comb begin
      enter_v = '0;
      leave_v = {1'b0, {QW{1'b1}}};
      for (int a = 0; a < 3; a++) begin
         if (!c1_tag_ff.cls.near[a]) begin
            if (c1_lo_ff[a] > enter_v) begin
               enter_v = c1_lo_ff[a];
            end
            if (c1_hi_ff[a] < leave_v) begin
               leave_v = c1_hi_ff[a];
            end
         end
      end
      hit_v = c1_tag_ff.vld && !c1_tag_ff.cls.reject && !(enter_v > leave_v);
   end

   always_ff @(posedge clock) begin
      c2_enter_ff <= enter_v[QW-1:0];
      plo_ff <= c2_enter_ff[HW-1:0] * dl_ff[DL-1];
      phi_ff <= c2_enter_ff[QW-1:HW] * dl_ff[DL-1];
      dist_ff <= dist_in;
   end

   always_comb begin
      full    = (PW'(phi_ff) << HW) + PW'(plo_ff);
      scaled  = full >> SLAB_FRAC;
      dist_in = '0;
      if (c3_hit_ff) begin
         dist_in = ((scaled >> DIST_W) != '0) ? '1 : scaled[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff   <= '0;
         c1_tag_ff <= '0;
         c2_hit_ff <= 1'b0;
         c2_vld_ff <= 1'b0;
         c3_hit_ff <= 1'b0;
         c3_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
         strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_W; i++) begin
            tag_ff[i] <= '0;
         end
      end else begin
         tag0_ff <= tag0_in;
         for (int i = 0; i < NUM_W; i++) begin
            if (i == 0) begin
               tag_ff[i] <= tag0_ff;
            end else begin
               tag_ff[i] <= tag_ff[i-1];
            end
         end
         c1_tag_ff <= tag_ff[NUM_W-1];
         c2_hit_ff <= hit_v;
         c2_vld_ff <= c1_tag_ff.vld;
         c3_hit_ff <= c2_hit_ff;
         c3_vld_ff <= c2_vld_ff;
         hit_ff    <= c3_hit_ff;
         strobe_ff <= c3_vld_ff;
      end
   end

   assign out_strobe   = strobe_ff;
   assign out_hit      = hit_ff;
   assign out_distance = dist_ff;

endmodule

>>> dv/testbench.sv
// Testbench for ray_box_hit_distance: random and directed rays over several inverse matrices.
// Depends on rbhd_pkg and the block RTL; expected hit/distance computed in place.
`timescale 1ns / 100ps

module testbench;
   import rbhd_pkg::*;

   typedef struct {
      logic [31:0] org [3];
      logic [31:0] dir [3];
   } ray_type;

   typedef struct {
      logic        hit;
      logic [31:0] distance;
   } hit_type;

   localparam int SETTLE = 90;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [31:0] req_origin_x = 0, req_origin_y = 0, req_origin_z = 0;
   logic [31:0] req_direction_x = 0, req_direction_y = 0, req_direction_z = 0;
   logic rsp_strobe, rsp_hit;
   logic [DIST_W-1:0] rsp_distance;
   logic csr_write_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [CSR_W-1:0] csr_wdata = 0;

   ray_box_hit_distance dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // shadow of the block's registers
   bit          visible = 0;
   logic [47:0] inv_col [3] = '{48'd0, 48'd0, 48'd0};
   logic [47:0] inv_off = 0;

   ray_type pending_rays [$];
   hit_type expected_hits [$];
   int      errors = 0;

   function automatic longint entry(logic [47:0] packed_v, int row);
      return longint'($signed(packed_v[16*row +: 16]));
   endfunction

   function automatic longint unsigned mag(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic longint slab_div(longint num, longint den);
      longint unsigned q;
      q = (mag(num) << SLAB_FRAC) / mag(den);
      return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic hit_type hit_distance(ray_type r);
      hit_type res;
      longint o [3], d [3], lo [3], ld [3], so, sd, m;
      longint enter, leave, s1, s2, t, half;
      longint unsigned dm [3], sq [3], maxm, ssum, thr, v, root, bitv, sh;
      logic [127:0] prod;
      bit have_leave, near;
      int k;
      res.hit = 0;
      res.distance = 0;
      half = 64'sd1 <<< 15;
      enter = 0;
      leave = 64'h7FFF_FFFF_FFFF_FFFF;
      have_leave = 0;
      maxm = 0;
      ssum = 0;
      k = 0;
      for (int a = 0; a < 3; a++) begin
         o[a] = longint'($signed(r.org[a]));
         d[a] = longint'($signed(r.dir[a]));
      end
      if (!visible) return res;
      for (int a = 0; a < 3; a++) begin
         so = entry(inv_off, a) * 65536;
         sd = 0;
         for (int j = 0; j < 3; j++) begin
            m = entry(inv_col[j], a);
            so += m * o[j];
            sd += m * d[j];
         end
         lo[a] = so >>> 12;
         ld[a] = sd >>> 12;
         dm[a] = mag(ld[a]);
         if (dm[a] > maxm) maxm = dm[a];
      end
      while (k < 63 && (maxm >> k) >= 64'd2147483648) k++;
      for (int a = 0; a < 3; a++) begin
         sh = dm[a] >> k;
         sq[a] = sh * sh;
         ssum += sq[a];
      end
      thr = (ssum + 64'd1000000000000 - 1) / 64'd1000000000000;
      for (int a = 0; a < 3; a++) begin
         near = (ssum == 0) || (sq[a] < thr);
         if (near) begin
            if (lo[a] < -half || lo[a] > half) return res;
            continue;
         end
         s1 = slab_div(-half - lo[a], ld[a]);
         s2 = slab_div(half - lo[a], ld[a]);
         if (s1 > s2) begin
            t = s1; s1 = s2; s2 = t;
         end
         if (s1 > enter) enter = s1;
         if (!have_leave || s2 < leave) begin
            leave = s2;
            have_leave = 1;
         end
         if (enter > leave) return res;
      end
      // integer square root of |d|^2
      v = mag(d[0]) * mag(d[0]) + mag(d[1]) * mag(d[1]) + mag(d[2]) * mag(d[2]);
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      res.hit = 1;
      prod = 128'($unsigned(enter)) * 128'(root);
      if (prod[127:64] != 0 || (prod >> SLAB_FRAC) > 128'hFFFF_FFFF) res.distance = '1;
      else res.distance = prod[51:20];
      return res;
   endfunction

   // driver: bursts of transfers with random gaps
   ray_type cur;
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else begin
         if (start && !busy) expected_hits.insert(expected_hits.size(), hit_distance(cur));
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 0;
            end else if (pending_rays.size() > 0) begin
               cur = pending_rays.pop_front();
               req_origin_x <= cur.org[0];
               req_origin_y <= cur.org[1];
               req_origin_z <= cur.org[2];
               req_direction_x <= cur.dir[0];
               req_direction_y <= cur.dir[1];
               req_direction_z <= cur.dir[2];
               start <= 1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end else begin
                  burst_left--;
               end
            end else begin
               start <= 0;
            end
         end
      end
   end

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // monitor
   hit_type want;
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_hits.size() == 0) begin
            report("unexpected transfer", {31'd0, rsp_hit}, 0);
         end else begin
            want = expected_hits.pop_front();
            if (rsp_hit !== want.hit) report("hit", {31'd0, rsp_hit}, {31'd0, want.hit});
            if (rsp_distance !== want.distance) report("distance", rsp_distance, want.distance);
         end
      end
   end

   task automatic add_ray(ray_type r);
      pending_rays.insert(pending_rays.size(), r);
   endtask

   task automatic csr_write(csr_index_type idx, logic [47:0] val);
      @(posedge clock);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_VISIBLE: visible = val[0];
         CSR_COL_X:   inv_col[0] = val;
         CSR_COL_Y:   inv_col[1] = val;
         CSR_COL_Z:   inv_col[2] = val;
         default:     inv_off = val;
      endcase
      @(posedge clock);
      csr_write_en <= 0;
   endtask

   task automatic load_matrix(logic [47:0] cx, logic [47:0] cy, logic [47:0] cz,
                              logic [47:0] ofs);
      csr_write(CSR_COL_X, cx);
      csr_write(CSR_COL_Y, cy);
      csr_write(CSR_COL_Z, cz);
      csr_write(CSR_OFFSET, ofs);
   endtask

   function automatic logic [47:0] diag_col(int row, logic [15:0] val);
      logic [47:0] c;
      c = 0;
      c[16*row +: 16] = val;
      return c;
   endfunction

   function automatic logic [31:0] rnd_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h8000_0000 | $urandom_range(0, 3);
         2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      endcase
   endfunction

   // mostly rays aimed near the box, some axis-parallel, zero or fully random
   function automatic ray_type rnd_ray();
      ray_type r;
      int mode;
      int tgt;
      mode = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
         r.org[a] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         tgt = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
         r.dir[a] = tgt - int'(r.org[a]);
         if (mode == 6) r.dir[a] = r.dir[a] >>> $urandom_range(0, 12);
         if (mode == 7) r.dir[a] = -r.dir[a];
         if (mode == 8) begin
            r.org[a] = rnd_coord();
            r.dir[a] = rnd_coord();
         end
      end
      if (mode == 9) begin
         r.dir = '{32'd0, 32'd0, 32'd0};
         r.dir[$urandom_range(0, 2)] = $urandom_range(0, 1) ? rnd_coord() : 32'd0;
      end
      return r;
   endfunction

   function automatic ray_type mk(int ox, int oy, int oz, int dx, int dy, int dz);
      ray_type r;
      r.org = '{ox, oy, oz};
      r.dir = '{dx, dy, dz};
      return r;
   endfunction

   task automatic drain();
      while (pending_rays.size() > 0 || expected_hits.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_rays(int n);
      repeat (n) add_ray(rnd_ray());
      drain();
   endtask

   function automatic logic [15:0] rnd_entry();
      return 16'($urandom_range(0, 16'h4000) - 16'h2000);
   endfunction

   initial begin
      localparam int ONE = 32'h0001_0000;
      repeat (2) @(posedge clock);
      reset <= 0;

      // invisible after reset
      add_ray(mk(0, 0, -2 * ONE, 0, 0, ONE));
      add_ray(mk(0, 0, 0, 0, 0, 0));
      random_rays(30);

      csr_write(CSR_VISIBLE, 48'd1);
      load_matrix(diag_col(0, 16'h1000), diag_col(1, 16'h1000), diag_col(2, 16'h1000), 0);
      add_ray(mk(0, 0, -2 * ONE, 0, 0, ONE));             // hit ahead
      add_ray(mk(0, 0, 2 * ONE, 0, 0, ONE));              // behind
      add_ray(mk(0, 0, 0, ONE, ONE, ONE));                // inside
      add_ray(mk(ONE / 4, 0, 0, 0, 0, 0));                // zero dir, inside
      add_ray(mk(ONE, 0, 0, 0, 0, 0));                    // zero dir, outside
      add_ray(mk(ONE, 0, -2 * ONE, 0, 0, ONE));           // parallel, outside
      add_ray(mk(ONE / 2, 0, -2 * ONE, 0, 0, ONE));       // parallel, on face
      add_ray(mk(0, 0, -2 * ONE, 1, 0, ONE));             // nearly parallel
      add_ray(mk(2 * ONE, 0, -2 * ONE, ONE, 0, ONE));     // empty overlap
      add_ray(mk(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0));
      add_ray(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      add_ray(mk(-3 * ONE, -3 * ONE, -3 * ONE, 1, 1, 1));
      random_rays(280);

      // tiny scale: huge box in world, saturating distances
      load_matrix(diag_col(0, 16'h0001), diag_col(1, 16'h0001), diag_col(2, 16'h0001), 0);
      add_ray(mk(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0));
      add_ray(mk(32'h8000_0000, 0, 0, 1, 0, 0));
      random_rays(150);

      repeat (2) begin
         load_matrix(diag_col(0, 16'($urandom_range(16'h0400, 16'h4000))),
                     diag_col(1, 16'($urandom_range(16'h0400, 16'h4000))),
                     diag_col(2, 16'($urandom_range(16'h0400, 16'h4000))),
                     {rnd_entry(), rnd_entry(), rnd_entry()} & 48'h03FF_03FF_03FF);
         random_rays(250);
      end
      repeat (3) begin
         load_matrix({rnd_entry(), rnd_entry(), rnd_entry()},
                     {rnd_entry(), rnd_entry(), rnd_entry()},
                     {rnd_entry(), rnd_entry(), rnd_entry()},
                     {rnd_entry(), rnd_entry(), rnd_entry()});
         random_rays(200);
      end
      load_matrix(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                  48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}));
      random_rays(120);
      load_matrix({3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}});
      random_rays(100);
      load_matrix(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h8000_8000_8000);
      random_rays(60);

      csr_write(CSR_VISIBLE, 48'd0);
      random_rays(40);

      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> filelist.f
sv/rbhd_pkg.sv
sv/rbhd_div.sv
sv/rbhd_sqrt.sv
sv/rbhd_front.sv
sv/rbhd_queue.sv
sv/rbhd_back.sv
sv/ray_box_hit_distance.sv
dv/testbench.sv
